// ----- src/upgrade_frame_builder_crc16_defines.svh -----
// Assertion macros shared by the frame builder RTL.
`ifndef UPGRADE_FRAME_BUILDER_CRC16_DEFINES_SVH
`define UPGRADE_FRAME_BUILDER_CRC16_DEFINES_SVH

// Same-cycle implication, checked on clk_i while out of reset.
`define UFB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, checked on clk_i while out of reset.
`define UFB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ----- src/ufb_pkg.sv -----
// Types, constants and CRC helpers for the upgrade frame builder.
`timescale 1ns / 1ps
package ufb_pkg;

  localparam int unsigned ADDR_W = 3;
  localparam logic REG_IDX_TARGET = 1'b0;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [7:0] SYNC_BYTE     = 8'hFF;
  localparam logic [7:0] DEV_COLLECTOR = 8'h02;
  localparam logic [7:0] DEV_INFERENCE = 8'h01;
  localparam logic [7:0] FLAG_START    = 8'h00;
  localparam logic [7:0] FLAG_DATA     = 8'h10;
  localparam logic [7:0] FLAG_STOP     = 8'h11;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_STOP  = 2'd2;

  typedef enum logic [3:0] {
    STEP_SYNC0,
    STEP_SYNC1,
    STEP_DEVICE,
    STEP_FLAG,
    STEP_NUM_HI,
    STEP_NUM_LO,
    STEP_LEN_LO,
    STEP_LEN_HI,
    STEP_DATA,
    STEP_CRC_LO,
    STEP_CRC_HI
  } step_e;

  typedef struct packed {
    logic target_is_collector;
  } cfg_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] kind_flag(input logic [1:0] kind);
    logic [7:0] f;
    case (kind)
      KIND_START: f = FLAG_START;
      KIND_STOP:  f = FLAG_STOP;
      default:    f = FLAG_DATA;
    endcase
    return f;
  endfunction

endpackage

// ----- src/upgrade_frame_builder_crc16.sv -----
// The first result of a transaction passes the input hold registers, then the output register.
// Throughput: one output byte per cycle while out_stall_i is low; a frame's first transaction
// holds the input for its header and data byte (header and CRC if the payload is empty, all
// if it also ends the frame), its last for data and CRC, every other for its data byte.
// Reset clears the frame state, sets the running CRC to 0xFFFF and selects the
// inference device type; no transaction is held after reset.
`timescale 1ns / 1ps
`include "upgrade_frame_builder_crc16_defines.svh"
module upgrade_frame_builder_crc16
  import ufb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        frame_kind_i,
  input  logic [15:0]       frame_number_i,
  input  logic [15:0]       payload_length_i,
  input  logic [7:0]        data_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic              run_last_o,
  output logic              frame_last_o
);

  cfg_t cfg;

  ufb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic        hold_valid_q, hold_valid_d;
  step_e       step_q, step_d;
  logic [1:0]  kind_q;
  logic [15:0] num_q;
  logic [15:0] len_q;
  logic [7:0]  data_q;

  logic [15:0] crc_q, crc_d;
  logic [15:0] bytes_taken_q, bytes_taken_d;
  logic [15:0] frame_size_q, frame_size_d;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q;
  logic        run_last_q;
  logic        frame_last_q;

  logic        advance;
  logic        in_accept;
  logic [7:0]  emit_byte;
  logic        emit_crc;
  logic        emit_done;
  logic        emit_flast;
  step_e       next_step;
  logic [15:0] bt_inc;

  assign advance    = hold_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = hold_valid_q && !(advance && emit_done);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign bt_inc     = bytes_taken_q + 16'd1;

  always_comb begin
    emit_byte     = 8'h00;
    emit_crc      = 1'b0;
    emit_done     = 1'b0;
    emit_flast    = 1'b0;
    next_step     = step_q;
    crc_d         = crc_q;
    bytes_taken_d = bytes_taken_q;
    frame_size_d  = frame_size_q;
    unique case (step_q)
      STEP_SYNC0: begin
        emit_byte = SYNC_BYTE;
        emit_crc  = 1'b1;
        next_step = STEP_SYNC1;
      end
      STEP_SYNC1: begin
        emit_byte = SYNC_BYTE;
        emit_crc  = 1'b1;
        next_step = STEP_DEVICE;
      end
      STEP_DEVICE: begin
        emit_byte = cfg.target_is_collector ? DEV_COLLECTOR : DEV_INFERENCE;
        emit_crc  = 1'b1;
        next_step = STEP_FLAG;
      end
      STEP_FLAG: begin
        emit_byte = kind_flag(kind_q);
        emit_crc  = 1'b1;
        next_step = STEP_NUM_HI;
      end
      STEP_NUM_HI: begin
        emit_byte = num_q[15:8];
        emit_crc  = 1'b1;
        next_step = STEP_NUM_LO;
      end
      STEP_NUM_LO: begin
        emit_byte = num_q[7:0];
        emit_crc  = 1'b1;
        next_step = STEP_LEN_LO;
      end
      STEP_LEN_LO: begin
        emit_byte = len_q[7:0];
        emit_crc  = 1'b1;
        next_step = STEP_LEN_HI;
      end
      STEP_LEN_HI: begin
        emit_byte = len_q[15:8];
        emit_crc  = 1'b1;
        next_step = (len_q == 16'd0) ? STEP_CRC_LO : STEP_DATA;
        if (advance) begin
          frame_size_d = len_q;
        end
      end
      STEP_DATA: begin
        emit_byte = data_q;
        emit_crc  = 1'b1;
        next_step = STEP_CRC_LO;
        emit_done = (bt_inc < frame_size_q);
        if (advance) begin
          bytes_taken_d = bt_inc;
        end
      end
      STEP_CRC_LO: begin
        emit_byte = crc_q[7:0];
        next_step = STEP_CRC_HI;
      end
      STEP_CRC_HI: begin
        emit_byte  = crc_q[15:8];
        emit_done  = 1'b1;
        emit_flast = 1'b1;
        if (advance) begin
          crc_d         = CRC_INIT;
          bytes_taken_d = 16'd0;
          frame_size_d  = 16'd0;
        end
      end
      default: begin
        emit_done = 1'b1;
      end
    endcase
    if (advance && emit_crc) begin
      crc_d = crc16_byte(crc_q, emit_byte);
    end
  end

  always_comb begin
    hold_valid_d = hold_valid_q;
    step_d       = step_q;
    if (in_accept) begin
      hold_valid_d = 1'b1;
      step_d       = (frame_size_d == 16'd0) ? STEP_SYNC0 : STEP_DATA;
    end else if (advance && emit_done) begin
      hold_valid_d = 1'b0;
    end else if (advance) begin
      step_d = next_step;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q  <= 1'b0;
      step_q        <= STEP_SYNC0;
      crc_q         <= CRC_INIT;
      bytes_taken_q <= 16'd0;
      frame_size_q  <= 16'd0;
      out_valid_q   <= 1'b0;
    end else begin
      hold_valid_q  <= hold_valid_d;
      step_q        <= step_d;
      crc_q         <= crc_d;
      bytes_taken_q <= bytes_taken_d;
      frame_size_q  <= frame_size_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q <= frame_kind_i;
      num_q  <= frame_number_i;
      len_q  <= payload_length_i;
      data_q <= data_byte_i;
    end
    if (advance) begin
      out_byte_q   <= emit_byte;
      run_last_q   <= emit_done;
      frame_last_q <= emit_flast;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign run_last_o   = run_last_q;
  assign frame_last_o = frame_last_q;

  `UFB_ASSERT_IMPL(a_flast_ends_run, out_valid_o && frame_last_o, run_last_o)
  `UFB_ASSERT_IMPL(a_idle_crc_init, !hold_valid_q && (frame_size_q == 16'd0), crc_q == CRC_INIT)
  `UFB_ASSERT_IMPL(a_count_in_frame, frame_size_q != 16'd0, bytes_taken_q <= frame_size_q)
  `UFB_ASSERT_NEXT(a_crc_hi_closes, advance && (step_q == STEP_CRC_HI), frame_size_q == 16'd0)
  `UFB_ASSERT_NEXT(a_accept_holds, in_accept, hold_valid_q)

endmodule

// ----- src/ufb_regs.sv -----
// APB configuration register block of the upgrade frame builder.
`timescale 1ns / 1ps
module ufb_regs
  import ufb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic wr_target;
  logic target_q;
  logic target_d;

  assign pready    = 1'b1;
  assign wr_target = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_IDX_TARGET);

  always_comb begin
    target_d = target_q;
    if (wr_target) begin
      target_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= 1'b0;
    end else begin
      target_q <= target_d;
    end
  end

  always_comb begin
    unique case (paddr[ADDR_W-1])
      REG_IDX_TARGET: prdata = {31'd0, target_q};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg_o.target_is_collector = target_q;

endmodule

// ----- test/tb_upgrade_frame_builder_crc16.sv -----
// Self-checking testbench for the upgrade frame builder: directed table and random frames.
`timescale 1ns / 1ps
module tb_upgrade_frame_builder_crc16;
  import ufb_pkg::*;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam logic [ADDR_W-1:0] TARGET_ADDR = ADDR_W'(4 * REG_IDX_TARGET);
  localparam int DRAIN_GUARD = 5000;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_last;
  } frame_byte_t;

  typedef struct packed {
    logic        cfg_wr;
    logic        cfg_val;
    logic [1:0]  kind;
    logic [15:0] num;
    logic [15:0] len;
    logic [7:0]  data;
    logic        typed;
    logic [7:0]  dev;
    logic [7:0]  flag;
  } stim_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        frame_kind_i;
  logic [15:0]       frame_number_i;
  logic [15:0]       payload_length_i;
  logic [7:0]        data_byte_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [7:0]        out_byte_o;
  logic              run_last_o;
  logic              frame_last_o;

  logic        cur_typed;
  logic [7:0]  cur_dev;
  logic [7:0]  cur_flag;

  frame_byte_t pending_bytes[$];
  frame_byte_t got_byte;
  logic        target_collector;
  logic [15:0] pred_crc;
  logic [15:0] pred_taken;
  logic [15:0] pred_size;
  int          mismatches;
  bit          quiet;
  int          stall_left;
  int          drv_left;
  stim_row_t   directed_rows[16];

  upgrade_frame_builder_crc16 i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .frame_kind_i     (frame_kind_i),
    .frame_number_i   (frame_number_i),
    .payload_length_i (payload_length_i),
    .data_byte_i      (data_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .run_last_o       (run_last_o),
    .frame_last_o     (frame_last_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  initial begin
    #50_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatches++;
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
  endtask

  function automatic logic [15:0] crc16_modbus_next(input logic [15:0] crc,
                                                    input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] flag_for_kind(input logic [1:0] kind);
    case (kind)
      KIND_START: return FLAG_START;
      KIND_STOP:  return FLAG_STOP;
      default:    return FLAG_DATA;
    endcase
  endfunction

  function automatic void predict_frame_bytes(input logic [1:0] kind, input logic [15:0] num,
                                              input logic [15:0] len, input logic [7:0] db,
                                              input logic typed, input logic [7:0] dev,
                                              input logic [7:0] flag);
    logic [7:0]  ob[11];
    logic        ofl[11];
    logic [7:0]  hdr[8];
    int          n;
    bit          closing;
    frame_byte_t e;
    n = 0;
    closing = 1'b0;
    if (pred_size == 16'd0) begin
      hdr[0] = SYNC_BYTE;
      hdr[1] = SYNC_BYTE;
      hdr[2] = typed ? dev : (target_collector ? DEV_COLLECTOR : DEV_INFERENCE);
      hdr[3] = typed ? flag : flag_for_kind(kind);
      hdr[4] = num[15:8];
      hdr[5] = num[7:0];
      hdr[6] = len[7:0];
      hdr[7] = len[15:8];
      pred_crc = 16'hFFFF;
      pred_taken = 16'd0;
      for (int i = 0; i < 8; i++) begin
        pred_crc = crc16_modbus_next(pred_crc, hdr[i]);
        ob[n] = hdr[i];
        ofl[n] = 1'b0;
        n++;
      end
      if (len == 16'd0) begin
        closing = 1'b1;
      end else begin
        pred_size = len;
      end
    end
    if (!closing) begin
      pred_crc = crc16_modbus_next(pred_crc, db);
      ob[n] = db;
      ofl[n] = 1'b0;
      n++;
      pred_taken = pred_taken + 16'd1;
      closing = (pred_taken >= pred_size);
    end
    if (closing) begin
      ob[n] = pred_crc[7:0];
      ofl[n] = 1'b0;
      n++;
      ob[n] = pred_crc[15:8];
      ofl[n] = 1'b1;
      n++;
      pred_crc = 16'hFFFF;
      pred_taken = 16'd0;
      pred_size = 16'd0;
    end
    for (int i = 0; i < n; i++) begin
      e.out_byte = ob[i];
      e.frame_last = ofl[i];
      e.run_last = (i == n - 1);
      pending_bytes = {pending_bytes, e};
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_frame_bytes(frame_kind_i, frame_number_i, payload_length_i, data_byte_i,
                            cur_typed, cur_dev, cur_flag);
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_bytes.size() == 0) begin
          report_mismatch("unexpected out_byte", {8'h00, out_byte_o}, 16'h0000);
        end else begin
          got_byte = pending_bytes.pop_front();
          if (out_byte_o !== got_byte.out_byte) begin
            report_mismatch("out_byte", {8'h00, out_byte_o}, {8'h00, got_byte.out_byte});
          end
          if (run_last_o !== got_byte.run_last) begin
            report_mismatch("run_last", {15'd0, run_last_o}, {15'd0, got_byte.run_last});
          end
          if (frame_last_o !== got_byte.frame_last) begin
            report_mismatch("frame_last", {15'd0, frame_last_o}, {15'd0, got_byte.frame_last});
          end
        end
      end
    end
  end

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  initial begin
    out_stall_i = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (quiet) begin
        out_stall_i <= 1'b0;
        stall_left = 0;
      end else if (stall_left != 0) begin
        stall_left--;
      end else if (out_stall_i) begin
        out_stall_i <= 1'b0;
        stall_left = $urandom_range(0, 8);
      end else if ($urandom_range(0, 99) < 30) begin
        out_stall_i <= 1'b1;
        stall_left = gap_len() - 1;
      end
    end
  end

  task automatic send_byte(input logic [1:0] kind, input logic [15:0] num,
                           input logic [15:0] len, input logic [7:0] data,
                           input logic typed, input logic [7:0] dev, input logic [7:0] flag);
    if (!quiet && $urandom_range(0, 99) < 25) begin
      in_valid_i <= 1'b0;
      repeat (gap_len()) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    frame_kind_i     <= kind;
    frame_number_i   <= num;
    payload_length_i <= len;
    data_byte_i      <= data;
    cur_typed        <= typed;
    cur_dev          <= dev;
    cur_flag         <= flag;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (pending_bytes.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_target_type(input logic val);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TARGET_ADDR;
    pwdata  <= {31'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    target_collector = val;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== {31'd0, val}) begin
      report_mismatch("prdata", rd[15:0], {15'd0, val});
    end
  endtask

  function automatic stim_row_t mk_row(input logic cfg_wr, input logic cfg_val,
                                       input logic [1:0] kind, input logic [15:0] num,
                                       input logic [15:0] len, input logic [7:0] data,
                                       input logic typed, input logic [7:0] dev,
                                       input logic [7:0] flag);
    stim_row_t r;
    r.cfg_wr = cfg_wr;
    r.cfg_val = cfg_val;
    r.kind = kind;
    r.num = num;
    r.len = len;
    r.data = data;
    r.typed = typed;
    r.dev = dev;
    r.flag = flag;
    return r;
  endfunction

  task automatic random_phase(input int n_items);
    logic [1:0]  kind;
    logic [15:0] len;
    int          pick;
    for (int s = 0; s < n_items; s++) begin
      if (drv_left == 0) begin
        quiet = ($urandom_range(0, 99) < 20);
        kind = ($urandom_range(0, 99) < 10) ? KIND_SPARE : 2'($urandom_range(0, 2));
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          len = 16'd0;
        end else if (pick < 83) begin
          len = 16'($urandom_range(1, 6));
        end else begin
          len = 16'($urandom_range(7, 48));
        end
        drv_left = (len == 16'd0) ? 0 : int'(len) - 1;
        send_byte(kind, 16'($urandom), len, 8'($urandom), 1'b0, 8'h00, 8'h00);
      end else begin
        drv_left--;
        send_byte(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), 8'($urandom),
                  1'b0, 8'h00, 8'h00);
      end
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_valid_i       = 1'b0;
    frame_kind_i     = KIND_START;
    frame_number_i   = '0;
    payload_length_i = 16'd1;
    data_byte_i      = '0;
    cur_typed        = 1'b0;
    cur_dev          = '0;
    cur_flag         = '0;
    target_collector = 1'b0;
    pred_crc         = 16'hFFFF;
    pred_taken       = '0;
    pred_size        = '0;
    mismatches       = 0;
    quiet            = 1'b0;
    drv_left         = 0;

    directed_rows[0]  = mk_row(0, 0, KIND_START, 16'h0000, 16'd1, 8'h00, 1, DEV_INFERENCE,
                               FLAG_START);
    directed_rows[1]  = mk_row(0, 0, KIND_STOP, 16'hFFFF, 16'd1, 8'hFF, 1, DEV_INFERENCE,
                               FLAG_STOP);
    directed_rows[2]  = mk_row(0, 0, KIND_SPARE, 16'h1234, 16'd0, 8'hA5, 1, DEV_INFERENCE,
                               FLAG_DATA);
    directed_rows[3]  = mk_row(0, 0, KIND_DATA, 16'h8001, 16'd3, 8'h5A, 1, DEV_INFERENCE,
                               FLAG_DATA);
    directed_rows[4]  = mk_row(0, 0, KIND_STOP, 16'hFFFF, 16'hFFFF, 8'h01, 0, 8'h00, 8'h00);
    directed_rows[5]  = mk_row(0, 0, KIND_START, 16'h0000, 16'h0000, 8'h80, 0, 8'h00, 8'h00);
    directed_rows[6]  = mk_row(1, 1, KIND_START, 16'h00FF, 16'd2, 8'h7F, 1, DEV_COLLECTOR,
                               FLAG_START);
    directed_rows[7]  = mk_row(0, 0, KIND_SPARE, 16'hAAAA, 16'h5555, 8'hFE, 0, 8'h00, 8'h00);
    directed_rows[8]  = mk_row(0, 0, KIND_DATA, 16'hFF00, 16'd4, 8'h33, 1, DEV_COLLECTOR,
                               FLAG_DATA);
    directed_rows[9]  = mk_row(1, 0, KIND_STOP, 16'h0F0F, 16'd1, 8'h44, 0, 8'h00, 8'h00);
    directed_rows[10] = mk_row(0, 0, KIND_START, 16'hF0F0, 16'd9, 8'hC3, 0, 8'h00, 8'h00);
    directed_rows[11] = mk_row(0, 0, KIND_DATA, 16'h1111, 16'd2, 8'h3C, 0, 8'h00, 8'h00);
    directed_rows[12] = mk_row(0, 0, KIND_STOP, 16'hABCD, 16'd2, 8'h96, 1, DEV_INFERENCE,
                               FLAG_STOP);
    directed_rows[13] = mk_row(0, 0, KIND_SPARE, 16'hFFFF, 16'hFFFF, 8'h69, 0, 8'h00, 8'h00);
    directed_rows[14] = mk_row(1, 1, KIND_SPARE, 16'h5555, 16'd0, 8'h12, 1, DEV_COLLECTOR,
                               FLAG_DATA);
    directed_rows[15] = mk_row(0, 0, KIND_START, 16'hAAAA, 16'd1, 8'h55, 1, DEV_COLLECTOR,
                               FLAG_START);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg_wr) begin
        drain_results();
        set_target_type(directed_rows[i].cfg_val);
      end
      send_byte(directed_rows[i].kind, directed_rows[i].num, directed_rows[i].len,
                directed_rows[i].data, directed_rows[i].typed, directed_rows[i].dev,
                directed_rows[i].flag);
    end

    for (int p = 0; p < 5; p++) begin
      drain_results();
      set_target_type(p[0] ^ 1'b0 ? 1'b1 : 1'b0);
      random_phase(78);
    end

    while (drv_left != 0) begin
      drv_left--;
      send_byte(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), 8'($urandom),
                1'b0, 8'h00, 8'h00);
    end
    quiet = 1'b0;

    drain_results();
    repeat (10) @(posedge clk_i);
    if (pending_bytes.size() != 0) begin
      report_mismatch("results never delivered", 16'(pending_bytes.size()), 16'd0);
    end
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/ufb_pkg.sv
src/ufb_regs.sv
src/upgrade_frame_builder_crc16.sv
test/tb_upgrade_frame_builder_crc16.sv
